// ----- design/palhr_pkg.sv -----
// shared types, constants and helper functions of the palette hue ramp remap block
package palhr_pkg;

    // one palette color, 8 bits per component
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // luminance 299r+587g+114b, at most 255000
    localparam int LUM_W = 18;
    // divisor is twice the maximum luminance
    localparam int DEN_W = LUM_W + 1;
    // dividend 2*c*lum + max, below 2^27
    localparam int NUM_W = DEN_W + 8;
    localparam int LANES = 3;
    // cycles from a target register write to a settled target color
    localparam int HSV_LAT = 3;
    localparam int SETTLE_W = $clog2(HSV_LAT + 1);

    typedef logic [LANES-1:0][NUM_W-1:0] num_vec_t;
    typedef logic [LANES-1:0][7:0] quo_vec_t;

    // word opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register indexes on the apb port
    localparam logic [2:0] CFG_HUE      = 3'd0;
    localparam logic [2:0] CFG_SAT      = 3'd1;
    localparam logic [2:0] CFG_VAL      = 3'd2;
    localparam logic [2:0] CFG_START    = 3'd3;
    localparam logic [2:0] CFG_END      = 3'd4;
    localparam logic [2:0] CFG_EXPANDED = 3'd5;

    function automatic logic [LUM_W-1:0] luma(rgb_t c);
        logic [LUM_W-1:0] lr;
        logic [LUM_W-1:0] lg;
        logic [LUM_W-1:0] lb;
        lr = LUM_W'(c.r) * LUM_W'(299);
        lg = LUM_W'(c.g) * LUM_W'(587);
        lb = LUM_W'(c.b) * LUM_W'(114);
        return lr + lg + lb;
    endfunction

    // six-bit component to eight bits by bit replication
    function automatic logic [7:0] widen6(logic [7:0] v);
        return {v[5:0], v[5:4]};
    endfunction

    // floor(x/255) for x up to 255*255
    function automatic logic [7:0] div255(logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- design/palhr_hsv.sv -----
// target color pipeline: integer hsv to rgb over three register stages
module palhr_hsv (
    input  logic               clk,
    input  logic [7:0]         hue,
    input  logic [7:0]         sat,
    input  logic [7:0]         val,
    output palhr_pkg::rgb_t    target
);

    typedef enum logic [2:0] {
        SEC_VTP = 3'd0,
        SEC_QVP = 3'd1,
        SEC_PVT = 3'd2,
        SEC_PQV = 3'd3,
        SEC_TPV = 3'd4,
        SEC_VPQ = 3'd5
    } sector_t;

    logic [10:0] hue6;
    logic [10:0] base;
    sector_t     sec;
    logic [7:0]  frac;

    sector_t         sec_a_reg;
    logic [15:0]     sf_a_reg;
    logic [15:0]     sfc_a_reg;
    logic [15:0]     vp_a_reg;
    logic [7:0]      v_a_reg;
    sector_t         sec_b_reg;
    logic [15:0]     qm_b_reg;
    logic [15:0]     tm_b_reg;
    logic [7:0]      p_b_reg;
    logic [7:0]      v_b_reg;
    palhr_pkg::rgb_t target_reg;
    logic [7:0]      q_c;
    logic [7:0]      t_c;
    palhr_pkg::rgb_t target_next;

    // hue*1530/255 is exactly 6*hue
    assign hue6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_comb
    begin
        if (hue6 >= 11'd1530)
        begin
            sec  = SEC_VTP;
            base = 11'd1530;
        end
        else if (hue6 >= 11'd1275)
        begin
            sec  = SEC_VPQ;
            base = 11'd1275;
        end
        else if (hue6 >= 11'd1020)
        begin
            sec  = SEC_TPV;
            base = 11'd1020;
        end
        else if (hue6 >= 11'd765)
        begin
            sec  = SEC_PQV;
            base = 11'd765;
        end
        else if (hue6 >= 11'd510)
        begin
            sec  = SEC_PVT;
            base = 11'd510;
        end
        else if (hue6 >= 11'd255)
        begin
            sec  = SEC_QVP;
            base = 11'd255;
        end
        else
        begin
            sec  = SEC_VTP;
            base = 11'd0;
        end
    end

    assign frac = 8'(hue6 - base);

    always_ff @(posedge clk)
    begin
        sec_a_reg <= sec;
        sf_a_reg  <= 16'(sat) * 16'(frac);
        sfc_a_reg <= 16'(sat) * 16'(8'd255 - frac);
        vp_a_reg  <= 16'(val) * 16'(8'd255 - sat);
        v_a_reg   <= val;

        sec_b_reg <= sec_a_reg;
        qm_b_reg  <= 16'(v_a_reg) * 16'(8'd255 - palhr_pkg::div255(sf_a_reg));
        tm_b_reg  <= 16'(v_a_reg) * 16'(8'd255 - palhr_pkg::div255(sfc_a_reg));
        p_b_reg   <= palhr_pkg::div255(vp_a_reg);
        v_b_reg   <= v_a_reg;

        target_reg <= target_next;
    end

    assign q_c = palhr_pkg::div255(qm_b_reg);
    assign t_c = palhr_pkg::div255(tm_b_reg);

    always_comb
    begin
        case (sec_b_reg)
            SEC_VTP: target_next = '{r: v_b_reg, g: t_c, b: p_b_reg};
            SEC_QVP: target_next = '{r: q_c, g: v_b_reg, b: p_b_reg};
            SEC_PVT: target_next = '{r: p_b_reg, g: v_b_reg, b: t_c};
            SEC_PQV: target_next = '{r: p_b_reg, g: q_c, b: v_b_reg};
            SEC_TPV: target_next = '{r: t_c, g: p_b_reg, b: v_b_reg};
            SEC_VPQ: target_next = '{r: v_b_reg, g: p_b_reg, b: q_c};
            default: target_next = '{r: v_b_reg, g: p_b_reg, b: q_c};
        endcase
    end

    assign target = target_reg;

endmodule

// ----- design/palhr_div.sv -----
// three-lane restoring divider, 8-bit quotient saturated at 255
module palhr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  palhr_pkg::num_vec_t           num,
    input  logic [palhr_pkg::DEN_W-1:0]   den,
    output palhr_pkg::quo_vec_t           quo,
    output logic                          done
);

    // one overflow check, then one quotient bit per cycle
    localparam int STEPS = 9;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    palhr_pkg::num_vec_t            rem_reg;
    logic [palhr_pkg::NUM_W-1:0]    dsh_reg;
    palhr_pkg::quo_vec_t            quo_reg;
    logic [palhr_pkg::LANES-1:0]    sat_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, 8'b0};
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < palhr_pkg::LANES; l++)
            begin
                if (cnt_reg == '0)
                begin
                    // quotient above 255 saturates
                    sat_reg[l] <= (rem_reg[l] >= dsh_reg);
                end
                else if (rem_reg[l] >= dsh_reg)
                begin
                    rem_reg[l] <= rem_reg[l] - dsh_reg;
                    quo_reg[l] <= {quo_reg[l][6:0], 1'b1};
                end
                else
                begin
                    quo_reg[l] <= {quo_reg[l][6:0], 1'b0};
                end
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_comb
    begin
        for (int l = 0; l < palhr_pkg::LANES; l++)
        begin
            quo[l] = sat_reg[l] ? 8'hFF : quo_reg[l];
        end
    end

    assign done = done_reg;

endmodule

// ----- design/palette_hue_ramp_remap_core.sv -----
// top level of the palette hue ramp remap block: apb registers, palette memory, control
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  apb      | psel penable pwrite paddr pwdata prdata  | in / out
//  in word  | in_valid in_ready op entry_index rgb_in  | in / out
//  out word | out_valid out_ready out_index rgb_out ok | out / in
//
// a load word writes the memory, then updates the maximum from its luminance
// a read word reads the memory, then goes to the put state when out of bounds,
//   outside the ramp or with a zero maximum, else after the multiply stage and
//   the done flag of the 9-step serial divider (overflow check, 8 quotient bits)
// reset clears config registers, max and control; palette memory is not cleared
// a finished word waits in the output register while the next word is taken;
//   a second result stalls until the output register is free
// after a register write the input side stalls while the hsv pipeline settles
module palette_hue_ramp_remap_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    // output words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_index,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        range_ok
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int IXW = (AW > 8) ? AW : 8;
    localparam int LUM_W = palhr_pkg::LUM_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_RDMEM = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_PUT   = 6'b100000
    } state_t;

    // configuration registers
    logic [7:0] target_hue_reg;
    logic [7:0] target_saturation_reg;
    logic [7:0] target_value_reg;
    logic [7:0] range_start_reg;
    logic [7:0] range_end_reg;
    logic       expanded_input_reg;
    logic [palhr_pkg::SETTLE_W-1:0] settle_reg;
    logic       cfg_wr;

    // control
    state_t state_reg;
    state_t state_next;
    logic   in_acc;
    logic   out_free;

    // per-word registers
    logic [7:0]       idx_reg;
    logic             inside_reg;
    logic             inb_reg;
    palhr_pkg::rgb_t  rgb_reg;
    logic [LUM_W-1:0] lum_reg;
    logic [LUM_W-1:0] max_lum_reg;
    logic [LUM_W-1:0] max_lum_next;

    // palette memory
    palhr_pkg::rgb_t  mem [PALETTE_ENTRIES];
    palhr_pkg::rgb_t  mem_q_reg;
    logic [IXW-1:0]   idx_ext;
    logic [AW-1:0]    addr;
    logic             in_bounds;
    logic             in_inside;
    palhr_pkg::rgb_t  wr_rgb;

    // arithmetic
    logic [LUM_W-1:0]    lum_comb;
    logic [LUM_W-1:0]    lum_base;
    palhr_pkg::rgb_t     target;
    palhr_pkg::num_vec_t div_num;
    palhr_pkg::quo_vec_t div_quo;
    logic                div_done;
    logic                div_start;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_index_reg;
    palhr_pkg::rgb_t out_rgb_reg;
    logic       range_ok_reg;
    palhr_pkg::rgb_t put_rgb;
    logic       put_ok;

    // ---------------- apb registers ----------------

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_hue_reg        <= 8'd0;
            target_saturation_reg <= 8'd0;
            target_value_reg      <= 8'd255;
            range_start_reg       <= 8'd0;
            range_end_reg         <= 8'd255;
            expanded_input_reg    <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                palhr_pkg::CFG_HUE:      target_hue_reg        <= pwdata[7:0];
                palhr_pkg::CFG_SAT:      target_saturation_reg <= pwdata[7:0];
                palhr_pkg::CFG_VAL:      target_value_reg      <= pwdata[7:0];
                palhr_pkg::CFG_START:    range_start_reg       <= pwdata[7:0];
                palhr_pkg::CFG_END:      range_end_reg         <= pwdata[7:0];
                palhr_pkg::CFG_EXPANDED: expanded_input_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            palhr_pkg::CFG_HUE:      prdata = {24'd0, target_hue_reg};
            palhr_pkg::CFG_SAT:      prdata = {24'd0, target_saturation_reg};
            palhr_pkg::CFG_VAL:      prdata = {24'd0, target_value_reg};
            palhr_pkg::CFG_START:    prdata = {24'd0, range_start_reg};
            palhr_pkg::CFG_END:      prdata = {24'd0, range_end_reg};
            palhr_pkg::CFG_EXPANDED: prdata = {31'd0, expanded_input_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // hold off input words while the target color pipeline settles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= palhr_pkg::SETTLE_W'(palhr_pkg::HSV_LAT);
        end
        else if (cfg_wr)
        begin
            settle_reg <= palhr_pkg::SETTLE_W'(palhr_pkg::HSV_LAT);
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    palhr_hsv u_hsv (
        .clk    (clk),
        .hue    (target_hue_reg),
        .sat    (target_saturation_reg),
        .val    (target_value_reg),
        .target (target)
    );

    // ---------------- input decode ----------------

    assign in_ready = (state_reg == S_IDLE) && (settle_reg == '0);
    assign in_acc   = in_valid && in_ready;

    assign idx_ext   = IXW'(entry_index);
    assign addr      = idx_ext[AW-1:0];
    assign in_bounds = {1'b0, idx_ext} < (IXW + 1)'(PALETTE_ENTRIES);
    // an empty ramp (start above end) never contains an index
    assign in_inside = (entry_index >= range_start_reg) && (entry_index <= range_end_reg);

    // six-bit mode replicates the top bits into the low bits
    always_comb
    begin
        if (expanded_input_reg)
        begin
            wr_rgb = '{r: red_in, g: green_in, b: blue_in};
        end
        else
        begin
            wr_rgb = '{r: palhr_pkg::widen6(red_in),
                       g: palhr_pkg::widen6(green_in),
                       b: palhr_pkg::widen6(blue_in)};
        end
    end

    // ---------------- palette memory ----------------

    always_ff @(posedge clk)
    begin
        if (in_acc && (op == palhr_pkg::OP_LOAD) && in_bounds)
        begin
            mem[addr] <= wr_rgb;
        end
        if (in_acc && (op == palhr_pkg::OP_READ) && in_bounds)
        begin
            mem_q_reg <= mem[addr];
        end
    end

    // ---------------- control ----------------

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (op == palhr_pkg::OP_LOAD) ? S_LOAD : S_RDMEM;
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_RDMEM:
            begin
                // scaling only for an in-bounds index inside the ramp with a nonzero maximum
                if (inb_reg && inside_reg && (max_lum_reg != '0))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- per-word datapath ----------------

    // one luminance unit: loaded color in the load state, memory data otherwise
    assign lum_comb = palhr_pkg::luma((state_reg == S_LOAD) ? rgb_reg : mem_q_reg);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            idx_reg    <= entry_index;
            inside_reg <= in_inside;
            inb_reg    <= in_bounds;
            rgb_reg    <= wr_rgb;
        end
        else if (state_reg == S_RDMEM)
        begin
            rgb_reg <= mem_q_reg;
            lum_reg <= lum_comb;
        end
    end

    // running maximum; a load of index zero restarts it
    always_comb
    begin
        lum_base     = (idx_reg == 8'd0) ? '0 : max_lum_reg;
        max_lum_next = max_lum_reg;
        if (inb_reg)
        begin
            max_lum_next = (inside_reg && (lum_comb > lum_base)) ? lum_comb : lum_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lum_reg <= '0;
        end
        else if (state_reg == S_LOAD)
        begin
            max_lum_reg <= max_lum_next;
        end
    end

    // dividend 2*c*lum + max per component, rounds half up against 2*max
    assign div_num[0] = palhr_pkg::NUM_W'({target.r, 1'b0}) * palhr_pkg::NUM_W'(lum_reg)
                      + palhr_pkg::NUM_W'(max_lum_reg);
    assign div_num[1] = palhr_pkg::NUM_W'({target.g, 1'b0}) * palhr_pkg::NUM_W'(lum_reg)
                      + palhr_pkg::NUM_W'(max_lum_reg);
    assign div_num[2] = palhr_pkg::NUM_W'({target.b, 1'b0}) * palhr_pkg::NUM_W'(lum_reg)
                      + palhr_pkg::NUM_W'(max_lum_reg);
    assign div_start  = (state_reg == S_MUL);

    palhr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({max_lum_reg, 1'b0}),
        .quo   (div_quo),
        .done  (div_done)
    );

    // ---------------- output register ----------------

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (!inb_reg)
        begin
            // index beyond the palette reads black
            put_rgb = '0;
            put_ok  = 1'b0;
        end
        else if (!inside_reg)
        begin
            put_rgb = rgb_reg;
            put_ok  = 1'b0;
        end
        else if (max_lum_reg == '0)
        begin
            put_rgb = '0;
            put_ok  = 1'b1;
        end
        else
        begin
            put_rgb = '{r: div_quo[0], g: div_quo[1], b: div_quo[2]};
            put_ok  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_PUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PUT) && out_free)
        begin
            out_index_reg <= idx_reg;
            out_rgb_reg   <= put_rgb;
            range_ok_reg  <= put_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign red_out   = out_rgb_reg.r;
    assign green_out = out_rgb_reg.g;
    assign blue_out  = out_rgb_reg.b;
    assign range_ok  = range_ok_reg;

    // ---------------- assertions ----------------

    // a register write must block input words while the target color settles
    assert property (@(posedge clk) disable iff (!rst_n) cfg_wr |=> !in_ready)
        else $error("input word taken right after a register write");

    // the running maximum only moves while a load finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |=> $stable(max_lum_reg))
        else $error("max luminance changed outside a load");

    // divider completion only expected while waiting on it
    assert property (@(posedge clk) disable iff (!rst_n) div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    // a new result appears only from the put state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PUT))
        else $error("result word raised outside the put state");

endmodule

// ----- tb/sv/palette_hue_ramp_remap_core_test.sv -----
// testbench of the palette hue ramp remap block: directed and random words checked against a predictor
module palette_hue_ramp_remap_core_test;

    // cycles waited once every expected word is back, covers a load still in flight
    localparam int SETTLE_CYCLES = 20;
    // run limit, far beyond the slowest correct run
    localparam int CYCLE_LIMIT = 250000;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 220;

    // one expected output word
    typedef struct {
        logic [7:0]      index;
        palhr_pkg::rgb_t color;
        logic            ok;
    } remap_word_t;

    // palette contents, ramp maximum and registers as the block should hold them
    class remap_ledger;
        palhr_pkg::rgb_t palette [256];
        int unsigned peak_lum;
        logic [7:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        logic [7:0]  ramp_lo;
        logic [7:0]  ramp_hi;
        logic        expanded;
        remap_word_t expected_words [$];
        int          mismatches;

        function new();
            peak_lum   = 0;
            hue        = 8'd0;
            sat        = 8'd0;
            val        = 8'd255;
            ramp_lo    = 8'd0;
            ramp_hi    = 8'd255;
            expanded   = 1'b1;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] data);
            case (idx)
                palhr_pkg::CFG_HUE:      hue = data;
                palhr_pkg::CFG_SAT:      sat = data;
                palhr_pkg::CFG_VAL:      val = data;
                palhr_pkg::CFG_START:    ramp_lo = data;
                palhr_pkg::CFG_END:      ramp_hi = data;
                palhr_pkg::CFG_EXPANDED: expanded = data[0];
                default:      ;
            endcase
        endfunction

        function int unsigned luminance(palhr_pkg::rgb_t c);
            int unsigned r;
            int unsigned g;
            int unsigned b;
            r = c.r;
            g = c.g;
            b = c.b;
            return 299 * r + 587 * g + 114 * b;
        endfunction

        // six-bit component stretched to eight bits
        function logic [7:0] stretch6(logic [7:0] v);
            int unsigned s;
            s = v & 8'h3f;
            return 8'((s << 2) | (s >> 4));
        endfunction

        // integer hsv to rgb of the target registers
        function palhr_pkg::rgb_t target_color();
            int unsigned h;
            int unsigned s;
            int unsigned v;
            int unsigned hh;
            int unsigned sector;
            int unsigned f;
            int unsigned p;
            int unsigned q;
            int unsigned t;
            palhr_pkg::rgb_t c;
            h = hue;
            s = sat;
            v = val;
            hh = (h * 1530 + 127) / 255;
            sector = (hh / 255) % 6;
            f = hh % 255;
            p = (v * (255 - s)) / 255;
            q = (v * (255 - (s * f) / 255)) / 255;
            t = (v * (255 - (s * (255 - f)) / 255)) / 255;
            case (sector)
                0:       c = {8'(v), 8'(t), 8'(p)};
                1:       c = {8'(q), 8'(v), 8'(p)};
                2:       c = {8'(p), 8'(v), 8'(t)};
                3:       c = {8'(p), 8'(q), 8'(v)};
                4:       c = {8'(t), 8'(p), 8'(v)};
                default: c = {8'(v), 8'(p), 8'(q)};
            endcase
            return c;
        endfunction

        // component times lum over the ramp maximum, rounded half up, saturated
        function logic [7:0] ramp_scale(logic [7:0] c, int unsigned lum);
            longint unsigned num;
            longint unsigned quo;
            if (peak_lum == 0)
                return 8'd0;
            num = 64'(c) * 64'(lum) * 2 + 64'(peak_lum);
            quo = num / (64'(peak_lum) * 2);
            return (quo > 255) ? 8'd255 : 8'(quo);
        endfunction

        // accepted input word: update the palette or predict the read
        function void take_word(logic op_bit, logic [7:0] idx, logic [7:0] r,
                                logic [7:0] g, logic [7:0] b);
            palhr_pkg::rgb_t c;
            palhr_pkg::rgb_t tc;
            remap_word_t     w;
            logic            in_ramp;
            int unsigned     lum;
            in_ramp = (ramp_lo <= ramp_hi) && (idx >= ramp_lo) && (idx <= ramp_hi);
            if (op_bit == palhr_pkg::OP_LOAD) begin
                if (expanded)
                    c = {r, g, b};
                else
                    c = {stretch6(r), stretch6(g), stretch6(b)};
                palette[idx] = c;
                if (idx == 8'd0)
                    peak_lum = 0;
                if (in_ramp && luminance(c) > peak_lum)
                    peak_lum = luminance(c);
            end
            else begin
                w.index = idx;
                w.ok = in_ramp;
                if (in_ramp) begin
                    lum = luminance(palette[idx]);
                    tc = target_color();
                    w.color = {ramp_scale(tc.r, lum), ramp_scale(tc.g, lum),
                               ramp_scale(tc.b, lum)};
                end
                else begin
                    w.color = palette[idx];
                end
                expected_words.insert(expected_words.size(), w);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // accepted output word against the oldest prediction
        function void match_word(logic [7:0] index, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b, logic ok);
            remap_word_t w;
            if (expected_words.size() == 0) begin
                $error("out word with nothing expected, out_index %0d", index);
                mismatches++;
                return;
            end
            w = expected_words.pop_front();
            compare_field("out_index", w.index, index);
            compare_field("red_out", w.color.r, r);
            compare_field("green_out", w.color.g, g);
            compare_field("blue_out", w.color.b, b);
            compare_field("range_ok", 8'(w.ok), 8'(ok));
        endfunction
    endclass

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // apb side, the block's inputs all driven from time zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // input word channel
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       op = palhr_pkg::OP_LOAD;
    logic [7:0] entry_index = 8'd0;
    logic [7:0] red_in = 8'd0;
    logic [7:0] green_in = 8'd0;
    logic [7:0] blue_in = 8'd0;

    // output word channel
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       range_ok;

    remap_ledger ledger;

    // random idling on both sides, switched off for the last phase
    bit idle_on = 1'b1;
    int out_stall_left = 0;
    int cycle_count = 0;

    // ramp as last written, used to aim the random indexes
    logic [7:0] cur_lo = 8'd0;
    logic [7:0] cur_hi = 8'd255;

    // indexes written so far; only these are ever read
    bit         was_loaded [256];
    logic [7:0] loaded_list [$];

    palette_hue_ramp_remap_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .entry_index (entry_index),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_index   (out_index),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .range_ok    (range_ok)
    );

    always #2 clk = ~clk;

    // output side: check every accepted word, then decide the next ready
    // values read here are the ones that held just before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.match_word(out_index, red_out, green_out, blue_out, range_ok);
        if (out_stall_left > 0)
            out_stall_left--;
        else if (idle_on && $urandom_range(0, 3) == 0)
            out_stall_left = $urandom_range(1, 5);
        out_ready <= (out_stall_left == 0);
    end

    // timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // apb write: setup cycle, access cycle, then a quiet wait so psel never
    // drops and rises in the same step
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, data};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.set_reg(idx, data);
        @(posedge clk);
    endtask

    // all six registers, only while the block is idle
    task automatic configure(input logic [7:0] hue, input logic [7:0] sat,
                             input logic [7:0] val, input logic [7:0] lo,
                             input logic [7:0] hi, input logic expanded);
        write_reg(palhr_pkg::CFG_HUE, hue);
        write_reg(palhr_pkg::CFG_SAT, sat);
        write_reg(palhr_pkg::CFG_VAL, val);
        write_reg(palhr_pkg::CFG_START, lo);
        write_reg(palhr_pkg::CFG_END, hi);
        write_reg(palhr_pkg::CFG_EXPANDED, {7'd0, expanded});
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // one input word; valid is lowered only when an idle burst comes, so a
    // back to back word keeps valid high with a single assignment per step
    task automatic send_word(input logic op_bit, input logic [7:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= op_bit;
        entry_index <= idx;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        do
            @(posedge clk);
        while (!in_ready);
        // accepted at this edge
        ledger.take_word(op_bit, idx, r, g, b);
        if (op_bit == palhr_pkg::OP_LOAD && !was_loaded[idx])
        begin
            was_loaded[idx] = 1'b1;
            loaded_list.insert(loaded_list.size(), idx);
        end
    endtask

    // wait until every read has come back, then let loads in flight settle
    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // extremes often, any value otherwise
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // index mostly inside the current ramp when the ramp is valid
    function automatic logic [7:0] ramp_index();
        if (cur_lo <= cur_hi && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(cur_lo, cur_hi));
        return 8'($urandom_range(0, 255));
    endfunction

    // random ramp, target and input mode
    task automatic random_setup();
        logic [7:0] lo;
        logic [7:0] hi;
        case ($urandom_range(0, 3))
            0:
            begin
                lo = 8'd0;
                hi = 8'd255;
            end
            1:
            begin
                lo = 8'($urandom_range(0, 255));
                hi = 8'($urandom_range(lo, 255));
            end
            2:
            begin
                lo = 8'($urandom_range(0, 255));
                hi = lo;
            end
            default:
            begin
                // start above end
                lo = 8'($urandom_range(1, 255));
                hi = 8'($urandom_range(0, lo - 1));
            end
        endcase
        configure(pick_byte(), pick_byte(), pick_byte(), lo, hi, 1'($urandom_range(0, 1)));
    endtask

    // mostly loads into the ramp and reads of written entries, with a clear of
    // the maximum now and then by a load of index zero
    task automatic random_words(input int count);
        int         n;
        int         roll;
        logic [7:0] idx;
        for (n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 15);
            idx = ramp_index();
            if (roll == 0)
                idx = 8'd0;
            if (roll < 8 || loaded_list.size() == 0)
                send_word(palhr_pkg::OP_LOAD, idx, pick_byte(), pick_byte(), pick_byte());
            else
            begin
                if (!was_loaded[idx])
                    idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                // color fields are don't care on a read, toggled anyway
                send_word(palhr_pkg::OP_READ, idx, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        int phase;
        ledger = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full ramp, pure red target, eight-bit input
        configure(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
        send_word(palhr_pkg::OP_LOAD, 8'd0, 8'd255, 8'd255, 8'd255);
        send_word(palhr_pkg::OP_LOAD, 8'd1, 8'd0, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_LOAD, 8'd2, 8'd255, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_LOAD, 8'd255, 8'd0, 8'd255, 8'd0);
        send_word(palhr_pkg::OP_LOAD, 8'd128, 8'd0, 8'd0, 8'd255);
        send_word(palhr_pkg::OP_READ, 8'd0, 8'd255, 8'd255, 8'd255);
        send_word(palhr_pkg::OP_READ, 8'd1, 8'd0, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_READ, 8'd2, 8'd170, 8'd85, 8'd170);
        send_word(palhr_pkg::OP_READ, 8'd255, 8'd85, 8'd170, 8'd85);
        send_word(palhr_pkg::OP_READ, 8'd128, 8'd0, 8'd0, 8'd0);
        // load of index zero with black clears the maximum: ramp reads go black
        send_word(palhr_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_READ, 8'd2, 8'd0, 8'd0, 8'd0);
        // small new maximum: brighter entries saturate
        send_word(palhr_pkg::OP_LOAD, 8'd3, 8'd10, 8'd20, 8'd30);
        send_word(palhr_pkg::OP_READ, 8'd2, 8'd0, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_READ, 8'd3, 8'd0, 8'd0, 8'd0);
        drain();

        // narrow ramp, black target, six-bit input with high bits set
        configure(8'd255, 8'd128, 8'd0, 8'd10, 8'd20, 1'b0);
        send_word(palhr_pkg::OP_LOAD, 8'd0, 8'd255, 8'd192, 8'd63);
        send_word(palhr_pkg::OP_LOAD, 8'd10, 8'd63, 8'd63, 8'd63);
        send_word(palhr_pkg::OP_LOAD, 8'd20, 8'd21, 8'd42, 8'd1);
        send_word(palhr_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_READ, 8'd10, 8'd0, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_READ, 8'd20, 8'd0, 8'd0, 8'd0);
        drain();

        // start above end: no ramp at all
        configure(8'd85, 8'd0, 8'd200, 8'd200, 8'd100, 1'b1);
        send_word(palhr_pkg::OP_LOAD, 8'd150, 8'd12, 8'd34, 8'd56);
        send_word(palhr_pkg::OP_READ, 8'd150, 8'd0, 8'd0, 8'd0);
        send_word(palhr_pkg::OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        drain();

        // random phases, the last one without idling
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            random_setup();
            random_words(WORDS_PER_PHASE);
            drain();
        end

        if (ledger.mismatches == 0 && ledger.expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
